// ===== hdl/frame_delta_time_smoother_unit_macros.svh =====
//------------------------------------------------------------------------------
// Frame delta time smoother assertion macros
// Shared shorthand for concurrent assertions, on aclk or on a given clock.
//------------------------------------------------------------------------------
`ifndef FRAME_DELTA_TIME_SMOOTHER_UNIT_MACROS_SVH
`define FRAME_DELTA_TIME_SMOOTHER_UNIT_MACROS_SVH

// Generic form: label, clock, active-low reset, property body, message.
`define FDTS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Block form on aclk / aresetn.
`define FDTS_ASSERT(lbl, prop, msg) \
    `FDTS_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

// ===== hdl/fdts_pkg.sv =====
//------------------------------------------------------------------------------
// Frame delta time smoother package
// Field widths, register codes and fixed-point constants shared by the block.
//------------------------------------------------------------------------------
package fdts_pkg;

    // Field widths
    localparam int NOW_W        = 48;
    localparam int FRAME_W      = 32;
    localparam int GAME_TIME_W  = 48;
    localparam int DELTA_W      = 32;
    localparam int SMOOTH_W     = 40;
    localparam int WEIGHT_W     = 17;
    localparam int TIME_SCALE_W = 15;
    localparam int MAX_STEP_W   = 24;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = FRAME_W + GAME_TIME_W + DELTA_W + SMOOTH_W;
    localparam int M_TUSER_W = 1;

    typedef logic [M_TDATA_W-1:0] m_tdata_t;

    // Default game time counter width
    localparam int TIME_BITS_DEF = 48;

    // Step limits, microseconds
    localparam logic [MAX_STEP_W-1:0] MIN_STEP_US     = 24'd10;
    localparam logic [MAX_STEP_W-1:0] STARTUP_STEP_US = 24'd20000;

    // Register reset values
    localparam logic [TIME_SCALE_W-1:0] TIME_SCALE_RST = 15'd256;
    localparam logic [MAX_STEP_W-1:0]   MAX_STEP_RST   = 24'd333333;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    localparam cfg_addr_t CFG_TIME_SCALE = 2'd0;
    localparam cfg_addr_t CFG_MAX_STEP   = 2'd1;
    localparam cfg_addr_t CFG_PAUSED     = 2'd2;

    // Command codes (tuser on the input side)
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // Shared multiplier: 24 x 20 -> 44
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MAX_STEP_W + MUL_B_W;
    localparam logic [PROD_W-1:0] SCALE_ROUND = 44'd128;
    localparam int SCALE_SHIFT = 8;

    // Weight update: floor((4w + 65538) / 5) = (num * 838861) >> 22
    localparam int WNUM_W = 19;
    localparam logic [WNUM_W-1:0]  WEIGHT_BIAS  = 19'd65538;
    localparam logic [MUL_B_W-1:0] RECIP5       = 20'd838861;
    localparam int RECIP5_SHIFT = 22;

    // Smoothing divider: (mag << 16 + div/2) / div, radix 4 restoring
    localparam int FRAC_W       = 16;
    localparam int DIV_W        = 19;
    localparam int NUM_W        = 58;
    localparam int DIV_BITS_CYC = 2;
    localparam int DIV_CYCLES   = NUM_W / DIV_BITS_CYC;
    localparam int CNT_W        = $clog2(DIV_CYCLES);

endpackage

// ===== hdl/frame_delta_time_smoother_unit.sv =====
//------------------------------------------------------------------------------
// Frame delta time smoother
// Flow: a tick passes the raw delta, clamp / pause selection, time scaling,
//   weight update and smoothing states; the startup tick skips the raw
//   delta and selection, a reset command or the first tick after it goes
//   straight to the output register.
// Items: one at a time; a new input word is taken only in the idle state.
//   The smoothing step is a radix-4 restoring divider, one shared 24x20
//   multiplier does the time scaling and the weight update. A stalled result
//   word holds the next item in the final state until the word is taken.
// Reset: aresetn is synchronous, active low; clears all timing state and
//   returns the configuration registers to their defaults.
//------------------------------------------------------------------------------
module frame_delta_time_smoother_unit #(
    parameter int TIME_BITS = fdts_pkg::TIME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fdts_pkg::S_TDATA_W-1:0]     s_tdata,   // [47:0] now_us
    input  logic [fdts_pkg::S_TUSER_W-1:0]     s_tuser,   // [0] command
    // Result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] frame_number, [79:32] game_time_us, [111:80] delta_us,
    // [151:112] smooth_delta
    output logic [fdts_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [fdts_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] time_advanced
    // Configuration writes
    input  logic                               cfg_wr_en,
    input  logic [fdts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [fdts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int MSW = fdts_pkg::MAX_STEP_W;
    localparam int TSW = fdts_pkg::TIME_SCALE_W;
    localparam int PW  = fdts_pkg::PROD_W;
    localparam int DW  = fdts_pkg::DIV_W;
    localparam int NW  = fdts_pkg::NUM_W;
    localparam int SW  = fdts_pkg::SMOOTH_W;

    // Sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;   // waiting for a word
    localparam logic [3:0] ST_RAW1  = 4'd1;   // now - zero offset
    localparam logic [3:0] ST_RAW2  = 4'd2;   // ... - game time = raw delta
    localparam logic [3:0] ST_SEL   = 4'd3;   // clamp / pause selection
    localparam logic [3:0] ST_MUL   = 4'd4;   // step * time_scale
    localparam logic [3:0] ST_ADV   = 4'd5;   // round, advance game time
    localparam logic [3:0] ST_WMUL  = 4'd6;   // (4w + bias) * 1/5
    localparam logic [3:0] ST_WSET  = 4'd7;   // new weight
    localparam logic [3:0] ST_DMAG  = 4'd8;   // divisor, target - smoothed
    localparam logic [3:0] ST_DABS  = 4'd9;   // magnitude
    localparam logic [3:0] ST_DLOAD = 4'd10;  // dividend with rounding term
    localparam logic [3:0] ST_DIV   = 4'd11;  // two quotient bits a cycle
    localparam logic [3:0] ST_DFIX  = 4'd12;  // cap and apply correction
    localparam logic [3:0] ST_FIN   = 4'd13;  // load output register

    // Sequencer
    logic [3:0]                         state_reg, state_next;
    logic [fdts_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    // Configuration
    logic [TSW-1:0]                     time_scale_reg, time_scale_next;
    logic [MSW-1:0]                     max_step_reg, max_step_next;
    logic                               paused_reg, paused_next;

    // Timing state
    logic [fdts_pkg::FRAME_W-1:0]       frame_cnt_reg, frame_cnt_next;
    logic                               after_rst_reg, after_rst_next;
    logic                               startup_reg, startup_next;
    logic [TIME_BITS-1:0]               frame_time_reg, frame_time_next;
    logic [fdts_pkg::DELTA_W-1:0]       step_reg, step_next;
    logic [SW-1:0]                      smooth_reg, smooth_next;
    logic [fdts_pkg::WEIGHT_W-1:0]      weight_reg, weight_next;
    logic [TIME_BITS-1:0]               zero_ofs_reg, zero_ofs_next;

    // Per-item working registers
    logic [TIME_BITS-1:0]               now_reg, now_next;
    logic [TIME_BITS-1:0]               raw_reg, raw_next;
    logic [MSW-1:0]                     x_reg, x_next;
    logic                               zero_w_reg, zero_w_next;
    logic                               adv_reg, adv_next;
    logic [PW-1:0]                      prod_reg, prod_next;
    logic [SW:0]                        diff_reg, diff_next;
    logic [SW-1:0]                      mag_reg, mag_next;
    logic [DW-1:0]                      div_reg, div_next;
    logic [NW-1:0]                      num_reg, num_next;
    logic [DW-1:0]                      rem_reg, rem_next;

    // Output register
    logic                               m_tvalid_reg, m_tvalid_next;
    fdts_pkg::m_tdata_t                 m_tdata_reg, m_tdata_next;
    logic [fdts_pkg::M_TUSER_W-1:0]     m_tuser_reg, m_tuser_next;

    // Shared multiplier operands
    logic [MSW-1:0]                     mul_a;
    logic [fdts_pkg::MUL_B_W-1:0]       mul_b;
    logic [fdts_pkg::WNUM_W-1:0]        wnum;

    // Divider step results
    logic [DW-1:0]                      rem_step;
    logic [NW-1:0]                      num_step;

    // Misc combinational helpers
    logic [fdts_pkg::FRAME_W-1:0]       frame_inc;
    logic [fdts_pkg::DELTA_W-1:0]       inc;
    logic [SW-1:0]                      q_cap;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // 4w + 65538, at most 327682
    assign wnum = {weight_reg, 2'b00} + fdts_pkg::WEIGHT_BIAS;

    // Weight update borrows the multiplier; every other use is step * scale
    always_comb begin
        if (state_reg == ST_WMUL) begin
            mul_a = MSW'(wnum);
            mul_b = fdts_pkg::RECIP5;
        end else begin
            mul_a = x_reg;
            mul_b = fdts_pkg::MUL_B_W'(time_scale_reg);
        end
    end

    // Round-to-nearest Q7.8 scaling; fits 32 bits for any 24-bit step
    assign inc = fdts_pkg::DELTA_W'((prod_reg + fdts_pkg::SCALE_ROUND) >>
                                    fdts_pkg::SCALE_SHIFT);

    assign frame_inc = frame_cnt_reg + 1'b1;

    // Quotient never needs to pass the magnitude
    assign q_cap = (num_reg > NW'(mag_reg)) ? mag_reg : num_reg[SW-1:0];

    // Restoring divider, two bits per cycle
    always_comb begin : div_step
        logic [DW:0]   rs;
        logic [DW-1:0] r;
        logic [NW-1:0] n;
        r  = rem_reg;
        n  = num_reg;
        rs = '0;
        for (int i = 0; i < fdts_pkg::DIV_BITS_CYC; i++) begin
            rs = {r, n[NW-1]};
            n  = {n[NW-2:0], 1'b0};
            if (rs >= {1'b0, div_reg}) begin
                rs   = rs - {1'b0, div_reg};
                n[0] = 1'b1;
            end
            r = rs[DW-1:0];
        end
        rem_step = r;
        num_step = n;
    end

    // Sequencer and datapath next state
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        time_scale_next = time_scale_reg;
        max_step_next   = max_step_reg;
        paused_next     = paused_reg;
        frame_cnt_next  = frame_cnt_reg;
        after_rst_next  = after_rst_reg;
        startup_next    = startup_reg;
        frame_time_next = frame_time_reg;
        step_next       = step_reg;
        smooth_next     = smooth_reg;
        weight_next     = weight_reg;
        zero_ofs_next   = zero_ofs_reg;
        now_next        = now_reg;
        raw_next        = raw_reg;
        x_next          = x_reg;
        zero_w_next     = zero_w_reg;
        adv_next        = adv_reg;
        prod_next       = prod_reg;
        diff_next       = diff_reg;
        mag_next        = mag_reg;
        div_next        = div_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        // Register writes; the user must make them only while idle, unchecked by the block
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                fdts_pkg::CFG_TIME_SCALE: time_scale_next = cfg_wdata[TSW-1:0];
                fdts_pkg::CFG_MAX_STEP:   max_step_next   = cfg_wdata[MSW-1:0];
                fdts_pkg::CFG_PAUSED:     paused_next     = cfg_wdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    now_next = TIME_BITS'(s_tdata);
                    adv_next = 1'b0;
                    if (s_tuser[0] == fdts_pkg::CMD_RESET) begin
                        // clear everything, resync to this clock reading
                        paused_next     = 1'b0;
                        frame_cnt_next  = '0;
                        after_rst_next  = 1'b1;
                        startup_next    = 1'b1;
                        frame_time_next = '0;
                        step_next       = '0;
                        smooth_next     = '0;
                        weight_next     = '0;
                        zero_ofs_next   = TIME_BITS'(s_tdata);
                        state_next      = ST_FIN;
                    end else begin
                        // frame count skips zero
                        frame_cnt_next = (frame_inc == '0) ?
                                         fdts_pkg::FRAME_W'(1) : frame_inc;
                        if (after_rst_reg) begin
                            after_rst_next = 1'b0;
                            state_next     = ST_FIN;
                        end else if (startup_reg) begin
                            startup_next = 1'b0;
                            x_next       = fdts_pkg::STARTUP_STEP_US;
                            zero_w_next  = 1'b1;
                            adv_next     = 1'b1;
                            state_next   = ST_MUL;
                        end else begin
                            adv_next   = 1'b1;
                            state_next = ST_RAW1;
                        end
                    end
                end
            end
            ST_RAW1: begin
                raw_next   = now_reg - zero_ofs_reg;
                state_next = ST_RAW2;
            end
            ST_RAW2: begin
                raw_next   = raw_reg - frame_time_reg;
                state_next = ST_SEL;
            end
            ST_SEL: begin
                // raw is signed; the clamps take precedence over pause
                zero_w_next = 1'b0;
                if (!raw_reg[TIME_BITS-1] && raw_reg > TIME_BITS'(max_step_reg)) begin
                    x_next = max_step_reg;
                end else if (raw_reg[TIME_BITS-1] ||
                             raw_reg < TIME_BITS'(fdts_pkg::MIN_STEP_US)) begin
                    x_next = fdts_pkg::MIN_STEP_US;
                end else if (paused_reg) begin
                    x_next      = '0;
                    zero_w_next = 1'b1;
                end else begin
                    // scale 256 reproduces raw exactly through the rounding
                    x_next = raw_reg[MSW-1:0];
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_ADV;
            end
            ST_ADV: begin
                step_next       = inc;
                frame_time_next = frame_time_reg + TIME_BITS'(inc);
                state_next      = ST_WMUL;
            end
            ST_WMUL: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_WSET;
            end
            ST_WSET: begin
                weight_next = fdts_pkg::WEIGHT_W'(prod_reg >> fdts_pkg::RECIP5_SHIFT);
                state_next  = ST_DMAG;
            end
            ST_DMAG: begin
                div_next      = {weight_reg, 2'b00} + DW'(weight_reg);
                diff_next     = {1'b0, step_reg, 8'h00} - {1'b0, smooth_reg};
                zero_ofs_next = now_reg - frame_time_reg;
                state_next    = ST_DABS;
            end
            ST_DABS: begin
                mag_next   = diff_reg[SW] ? (~diff_reg[SW-1:0] + 1'b1) : diff_reg[SW-1:0];
                state_next = ST_DLOAD;
            end
            ST_DLOAD: begin
                num_next   = {mag_reg, {fdts_pkg::FRAC_W{1'b0}}} + NW'(div_reg >> 1);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                num_next = num_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == fdts_pkg::CNT_W'(fdts_pkg::DIV_CYCLES - 1)) begin
                    state_next = ST_DFIX;
                end
            end
            ST_DFIX: begin
                smooth_next = diff_reg[SW] ? (smooth_reg - q_cap) : (smooth_reg + q_cap);
                if (zero_w_reg) begin
                    weight_next = '0;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // wait for the output slot to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {smooth_reg, step_reg,
                                     fdts_pkg::GAME_TIME_W'(frame_time_reg),
                                     frame_cnt_reg};
                    m_tuser_next  = adv_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and timing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            time_scale_reg <= fdts_pkg::TIME_SCALE_RST;
            max_step_reg   <= fdts_pkg::MAX_STEP_RST;
            paused_reg     <= 1'b0;
            frame_cnt_reg  <= '0;
            after_rst_reg  <= 1'b1;
            startup_reg    <= 1'b1;
            frame_time_reg <= '0;
            step_reg       <= '0;
            smooth_reg     <= '0;
            weight_reg     <= '0;
            zero_ofs_reg   <= '0;
            zero_w_reg     <= 1'b0;
            adv_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            time_scale_reg <= time_scale_next;
            max_step_reg   <= max_step_next;
            paused_reg     <= paused_next;
            frame_cnt_reg  <= frame_cnt_next;
            after_rst_reg  <= after_rst_next;
            startup_reg    <= startup_next;
            frame_time_reg <= frame_time_next;
            step_reg       <= step_next;
            smooth_reg     <= smooth_next;
            weight_reg     <= weight_next;
            zero_ofs_reg   <= zero_ofs_next;
            zero_w_reg     <= zero_w_next;
            adv_reg        <= adv_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Working payload, no reset
    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        raw_reg     <= raw_next;
        x_reg       <= x_next;
        prod_reg    <= prod_next;
        diff_reg    <= diff_next;
        mag_reg     <= mag_next;
        div_reg     <= div_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

// ===== hdl/fdts_checker.sv =====
//------------------------------------------------------------------------------
// Frame delta time smoother port checker
// Watches the stream ports of the smoother over time; bound to the top level.
//------------------------------------------------------------------------------
`include "frame_delta_time_smoother_unit_macros.svh"

module fdts_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fdts_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [fdts_pkg::M_TUSER_W-1:0]  m_tuser
);

    // stalled result word holds
    `FDTS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // one item at a time: busy right after an accept
    `FDTS_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input ready right after an accept")

    // an advance always belongs to a counted frame
    `FDTS_ASSERT(a_adv_frame, m_tvalid && m_tuser[0] |-> m_tdata[31:0] != 32'd0, "time advanced on frame zero")

    // frame zero only after a reset command, which clears all timing
    `FDTS_ASSERT(a_frame_zero_clear, m_tvalid && m_tdata[31:0] == 32'd0 |-> m_tdata[151:32] == 120'd0, "frame zero with timing state")

endmodule

bind frame_delta_time_smoother_unit fdts_checker u_fdts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/tb_frame_delta_time_smoother_unit.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Frame delta time smoother testbench
// Streams frame ticks and reset commands into the block. A clocked driver
// takes them from a backlog queue, and a clocked monitor checks every result
// word against a behavioral predictor of the timing state. Phases change the
// registers while the block is idle and vary the idling on both sides. One
// phase holds the result side off long enough to back up the input.
//------------------------------------------------------------------------------
module tb_frame_delta_time_smoother_unit;
    import fdts_pkg::*;

    localparam int HOLD_CYCLES = 500;    // long receiver hold-off
    localparam int SETTLE_CYCLES = 60;   // settle time after the last drain

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // One input word: command in tuser, clock reading in tdata
    typedef struct {
        logic              cmd;
        logic [NOW_W-1:0]  now_us;
    } tick_word_t;

    // One result word, as the predictor sees it
    typedef struct {
        logic [FRAME_W-1:0]     frame_number;
        logic [GAME_TIME_W-1:0] game_time_us;
        logic [DELTA_W-1:0]     delta_us;
        logic [SMOOTH_W-1:0]    smooth_delta;
        logic                   time_advanced;
    } frame_result_t;

    // DUT ports, all inputs known from time zero
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;     // [47:0] now_us
    logic [S_TUSER_W-1:0]  s_tuser = '0;     // [0] command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [31:0] frame_number, [79:32] game_time_us, [111:80] delta_us,
    // [151:112] smooth_delta
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;          // [0] time_advanced
    logic                  cfg_wr_en = 1'b0;
    cfg_addr_t             cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Words waiting to be offered, and results waiting to arrive
    tick_word_t    tick_backlog[$];
    frame_result_t timing_due[$];

    int fail_count = 0;
    int idle_pct = 0;       // sender idle chance, percent
    int stall_pct = 0;      // receiver stall chance, percent

    // Hold-off request: main toggles hold_trig, the counter process reloads
    bit hold_trig = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    // Shadow of the configuration registers
    logic [TIME_SCALE_W-1:0] shadow_scale = TIME_SCALE_RST;
    logic [MAX_STEP_W-1:0]   shadow_max_step = MAX_STEP_RST;
    logic                    shadow_paused = 1'b0;

    // Predicted timing state, at reset values
    logic [FRAME_W-1:0]     pr_frames = '0;
    logic                   pr_skip_first = 1'b1;   // first tick after reset
    logic                   pr_startup = 1'b1;      // startup step pending
    logic [GAME_TIME_W-1:0] pr_game_time = '0;
    logic [DELTA_W-1:0]     pr_delta = '0;
    logic [SMOOTH_W-1:0]    pr_smooth = '0;         // Q32.8
    logic [WEIGHT_W-1:0]    pr_weight = '0;         // Q1.16
    logic [NOW_W-1:0]       pr_offset = '0;

    // Stimulus clock: where the simulated wall clock stands
    logic [NOW_W-1:0] gen_clock = '0;

    always #2 aclk = ~aclk;

    frame_delta_time_smoother_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    //--------------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------------

    // Q7.8 time scaling, round to nearest
    function automatic logic [63:0] scale_step(input logic [63:0] x);
        logic [63:0] factor;
        factor = {49'd0, shadow_scale};
        return (x * factor + 64'd128) >> 8;
    endfunction

    // Step game time by inc, update the smoothed delta, resync the offset
    task automatic advance_time(input logic [63:0] inc, input logic [NOW_W-1:0] now);
        logic [63:0] w, dv, target, cur, mag, q;
        logic        neg;
        pr_delta = (inc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : inc[31:0];
        pr_game_time = pr_game_time + inc[GAME_TIME_W-1:0];
        // w = 0.8w + 0.2 in Q1.16, floored
        w = (64'd4 * {47'd0, pr_weight} + 64'd65538) / 64'd5;
        pr_weight = w[WEIGHT_W-1:0];
        dv = 64'd5 * w;
        target = {24'd0, pr_delta, 8'd0};
        cur = {24'd0, pr_smooth};
        neg = target < cur;
        mag = neg ? cur - target : target - cur;
        q = (mag * 64'd65536 + dv / 64'd2) / dv;
        // never overshoot the new delta
        if (q > mag)
            q = mag;
        pr_smooth = neg ? pr_smooth - q[SMOOTH_W-1:0] : pr_smooth + q[SMOOTH_W-1:0];
        pr_offset = now - pr_game_time;
    endtask

    task automatic predict_timing(input logic cmd, input logic [NOW_W-1:0] now);
        frame_result_t    r;
        logic [NOW_W-1:0] raw;
        logic             adv;
        adv = 1'b0;
        if (cmd == CMD_RESET) begin
            // reset command also drops the pause
            shadow_paused = 1'b0;
            pr_frames = '0;
            pr_skip_first = 1'b1;
            pr_startup = 1'b1;
            pr_game_time = '0;
            pr_delta = '0;
            pr_smooth = '0;
            pr_weight = '0;
            pr_offset = now;
        end else begin
            pr_frames = pr_frames + 1'b1;
            if (pr_frames == '0)
                pr_frames = 32'd1;
            if (pr_skip_first) begin
                pr_skip_first = 1'b0;
            end else if (pr_startup) begin
                pr_startup = 1'b0;
                advance_time(scale_step({40'd0, STARTUP_STEP_US}), now);
                pr_weight = '0;
                adv = 1'b1;
            end else begin
                // raw delta, read as signed at the time width
                raw = (now - pr_offset) - pr_game_time;
                adv = 1'b1;
                if (!raw[NOW_W-1] && raw > {24'd0, shadow_max_step}) begin
                    advance_time(scale_step({40'd0, shadow_max_step}), now);
                end else if (raw[NOW_W-1] || raw < {24'd0, MIN_STEP_US}) begin
                    advance_time(scale_step({40'd0, MIN_STEP_US}), now);
                end else if (shadow_paused) begin
                    advance_time(64'd0, now);
                    pr_weight = '0;
                end else if (shadow_scale != TIME_SCALE_RST) begin
                    advance_time(scale_step({16'd0, raw}), now);
                end else begin
                    advance_time({16'd0, raw}, now);
                end
            end
        end
        r.frame_number = pr_frames;
        r.game_time_us = pr_game_time;
        r.delta_us = pr_delta;
        r.smooth_delta = pr_smooth;
        r.time_advanced = adv;
        timing_due.push_back(r);
    endtask

    //--------------------------------------------------------------------------
    // Driver: offers backlog words, predicts each accepted word
    //--------------------------------------------------------------------------
    always @(posedge aclk) begin
        tick_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_timing(s_tuser[0], s_tdata);
            // a word stays up until taken; only then pick the next one
            if (!s_tvalid || s_tready) begin
                if (tick_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    w = tick_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= w.cmd;
                    s_tdata <= w.now_us;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter
    always @(posedge aclk) begin
        if (hold_trig != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_trig;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    //--------------------------------------------------------------------------
    // Monitor: checks result words in order
    //--------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (timing_due.size() == 0) begin
                $error("result word with no prediction pending");
                fail_count++;
            end else begin
                want = timing_due.pop_front();
                check_field("frame_number", 64'(want.frame_number), 64'(m_tdata[31:0]));
                check_field("game_time_us", 64'(want.game_time_us), 64'(m_tdata[79:32]));
                check_field("delta_us", 64'(want.delta_us), 64'(m_tdata[111:80]));
                check_field("smooth_delta", 64'(want.smooth_delta),
                            64'(m_tdata[151:112]));
                check_field("time_advanced", 64'(want.time_advanced), 64'(m_tuser[0]));
            end
        end
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    //--------------------------------------------------------------------------
    // Stimulus helpers
    //--------------------------------------------------------------------------
    task automatic queue_word(input logic cmd, input logic [NOW_W-1:0] now);
        tick_word_t w;
        w.cmd = cmd;
        w.now_us = now;
        gen_clock = now;
        tick_backlog.push_back(w);
    endtask

    task automatic queue_tick(input logic [NOW_W-1:0] delta);
        queue_word(CMD_TICK, gen_clock + delta);
    endtask

    // Mostly plausible frame deltas, with clamps, jumps and resets mixed in
    task automatic queue_random(input int count);
        int          r;
        logic [63:0] rnd;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            rnd = {$urandom, $urandom};
            if (r < 3)
                queue_word(CMD_RESET, rnd[NOW_W-1:0]);
            else if (r < 7)
                queue_word(CMD_TICK, rnd[NOW_W-1:0]);          // clock jump
            else if (r < 10)
                queue_word(CMD_TICK, gen_clock - $urandom_range(5000, 1)); // backward
            else if (r < 15)
                queue_tick(NOW_W'($urandom_range(12)));         // short frame
            else if (r < 22)
                queue_tick({24'd0, shadow_max_step} + $urandom_range(2000000, 1));
            else if (r < 27)
                queue_tick({24'd0, shadow_max_step} + $urandom_range(2) - 1);
            else
                queue_tick(NOW_W'($urandom_range(50000, 10)));
        end
    endtask

    task automatic write_reg(input cfg_addr_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_TIME_SCALE: shadow_scale = val[TIME_SCALE_W-1:0];
            CFG_MAX_STEP:   shadow_max_step = val;
            CFG_PAUSED:     shadow_paused = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin idle_pct = 62; stall_pct = 0;  end
            IDLE_RECV: begin idle_pct = 0;  stall_pct = 62; end
            default:   begin idle_pct = 17; stall_pct = 17; end
        endcase
    endtask

    // Everything offered, taken and answered
    task automatic wait_drained();
        while (tick_backlog.size() != 0 || s_tvalid || timing_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] scale,
                             input logic [CFG_DATA_W-1:0] max_step,
                             input logic [CFG_DATA_W-1:0] pause,
                             input idle_mode_t mode, input int count);
        write_reg(CFG_TIME_SCALE, scale);
        write_reg(CFG_MAX_STEP, max_step);
        write_reg(CFG_PAUSED, pause);
        set_idling(mode);
        @(negedge aclk);
        queue_random(count);
        wait_drained();
    endtask

    //--------------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------------
    initial begin
        logic [23:0] junk;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, default registers
        set_idling(IDLE_NONE);
        queue_word(CMD_TICK, '0);           // first tick after reset: ignored
        queue_tick(16667);                  // startup step
        queue_tick(16667);                  // real time
        queue_tick(16667);
        queue_tick(10);                     // exactly the minimum
        queue_tick(9);                      // short
        queue_tick(0);
        queue_tick(333333);                 // exactly the maximum
        queue_tick(333334);                 // long
        queue_tick(5000000);
        queue_word(CMD_TICK, gen_clock - 1000);  // clock went backward
        queue_word(CMD_RESET, 48'hFFFF_FFFF_FFF0);
        queue_tick(100);
        queue_tick(100);                    // startup, after the clock wrapped
        queue_tick(20);
        queue_tick(30000);
        queue_tick(30000);
        queue_word(CMD_TICK, '1);           // all-ones reading
        queue_word(CMD_RESET, '1);
        queue_word(CMD_RESET, '0);          // back-to-back resets
        queue_tick(1);
        queue_tick(1);
        queue_tick(16667);
        wait_drained();

        // Random phases over the register range
        run_phase(24'd256, 24'd333333, 24'd0, IDLE_NONE, 120);
        run_phase(24'd512, 24'd50000, 24'd0, IDLE_SEND, 110);
        run_phase(24'd128, 24'd333333, 24'd1, IDLE_RECV, 110);
        run_phase(24'd0, 24'd0, 24'd0, IDLE_BOTH, 100);
        run_phase(24'h007FFF, 24'hFFFFFF, 24'd1, IDLE_BOTH, 100);

        // Pressure: upper write bits are don't-care, receiver held off
        junk = 24'($urandom);
        write_reg(CFG_TIME_SCALE, {junk[23:15], 15'd25600});
        write_reg(CFG_MAX_STEP, 24'd16667);
        write_reg(CFG_PAUSED, {junk[22:0], 1'b0});
        set_idling(IDLE_NONE);
        @(posedge aclk);
        hold_trig <= ~hold_trig;
        @(negedge aclk);
        queue_random(100);
        wait_drained();

        run_phase(24'd256, 24'd40000, 24'd1, IDLE_RECV, 100);
        run_phase({24'd256}, {24'd333333}, 24'd0, IDLE_BOTH, 60);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
